// ----- src/tsb_pkg.sv -----
package tsb_pkg;

  // Bank geometry
  localparam int unsigned Slots = 32;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned MsW   = 10;
  localparam int unsigned PerW  = 32;

  // Reset value of the per-tick increment
  localparam logic [MsW-1:0] MsPerTickRst = MsW'(10);

  // Input opcodes
  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_ARMED     = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_EXPIRED   = 3'd2;
  localparam logic [2:0] KIND_CANCELLED = 3'd3;
  localparam logic [2:0] KIND_TICK_DONE = 3'd4;

  // Command transaction
  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  slot_index;
    logic [31:0] period_ms;
    logic        repeat_req;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] slot_id;
    logic       last;
  } rsp_t;

endpackage

// ----- src/timeout_slot_bank_core.sv -----
// Timeout slot bank: 32 one-shot or periodic timeout slots.
//
// Command channel: in_i is taken at a rising edge with start_i high and
// busy_o low. Arm takes the lowest free slot, cancel frees the named slot,
// tick advances every active slot with a nonzero period by ms_per_tick.
// Result channel: out_o is valid for exactly one cycle while out_valid_o is
// high; the receiver cannot stall it. The final result of a command has last
// set.
// Flow: arm and cancel report in the cycle after acceptance and leave
// busy_o low, so one command per cycle is taken. A tick scans the slots
// one per cycle through the period and sum memories (registered read,
// write-back the next cycle); expiries come out in slot order as found, and
// the tick-done result follows the last slot. busy_o is high for the scan.
// Config channel: cfg_data_i is written into ms_per_tick when cfg_valid_i is
// high; cfg_ready_o is always high. Write only while no command is pending.
// Reset: all slots free, ms_per_tick back to 10; the slot memories are not
// cleared, since a slot is always written on arm before it is read.
module timeout_slot_bank_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  tsb_pkg::cmd_t                   in_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  output tsb_pkg::rsp_t                   out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tsb_pkg::MsW-1:0]         cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [tsb_pkg::MsW-1:0]     ms_per_tick_q;
  logic [tsb_pkg::Slots-1:0]   active_q, active_d;
  logic [tsb_pkg::Slots-1:0]   periodic_q, periodic_d;
  logic [tsb_pkg::SlotW-1:0]   cmp_idx_q, cmp_idx_d;
  logic                        out_valid_q, out_valid_d;
  tsb_pkg::rsp_t               out_q, out_d;

  // Slot memories
  logic [tsb_pkg::PerW-1:0]    mem_per [tsb_pkg::Slots];
  logic [tsb_pkg::PerW-1:0]    mem_sum [tsb_pkg::Slots];
  logic [tsb_pkg::PerW-1:0]    per_rd_q, sum_rd_q;
  logic                        rd_en;
  logic [tsb_pkg::SlotW-1:0]   rd_addr;
  logic                        per_wr_en, sum_wr_en;
  logic [tsb_pkg::SlotW-1:0]   sum_wr_addr;
  logic [tsb_pkg::PerW-1:0]    sum_wr_data;

  logic                        accept;
  logic                        any_free;
  logic [tsb_pkg::SlotW-1:0]   free_idx;
  logic                        scan_last;
  logic                        scan_live;
  logic                        scan_hit;
  logic [tsb_pkg::PerW:0]      sum_ext;
  logic [tsb_pkg::PerW-1:0]    sum_sat;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i & ~busy_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = tsb_pkg::Slots - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = tsb_pkg::SlotW'(i);
      end
    end
  end
  assign any_free = ~&active_q;

  // Per-slot tick update, data from the memory read issued last cycle
  assign scan_last = (cmp_idx_q == tsb_pkg::SlotW'(tsb_pkg::Slots - 1));
  assign scan_live = active_q[cmp_idx_q] & (per_rd_q != '0);
  assign sum_ext   = {1'b0, sum_rd_q} + {{(tsb_pkg::PerW + 1 - tsb_pkg::MsW){1'b0}},
                                         ms_per_tick_q};
  assign sum_sat   = sum_ext[tsb_pkg::PerW] ? '1 : sum_ext[tsb_pkg::PerW-1:0];
  assign scan_hit  = scan_live & (sum_sat >= per_rd_q);

  // Control and memory port selection
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    periodic_d  = periodic_q;
    cmp_idx_d   = cmp_idx_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    per_wr_en   = 1'b0;
    sum_wr_en   = 1'b0;
    sum_wr_addr = free_idx;
    sum_wr_data = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.opcode == tsb_pkg::OP_ARM) begin
            out_valid_d  = 1'b1;
            out_d.last   = 1'b1;
            if (any_free) begin
              active_d[free_idx]   = 1'b1;
              periodic_d[free_idx] = in_i.repeat_req;
              per_wr_en    = 1'b1;
              sum_wr_en    = 1'b1;
              out_d.kind   = tsb_pkg::KIND_ARMED;
              out_d.slot_id = 5'(free_idx);
            end else begin
              out_d.kind    = tsb_pkg::KIND_FULL;
              out_d.slot_id = '0;
            end
          end else if (in_i.opcode == tsb_pkg::OP_CANCEL) begin
            if ({1'b0, in_i.slot_index} < 6'(tsb_pkg::Slots)) begin
              active_d[in_i.slot_index[tsb_pkg::SlotW-1:0]] = 1'b0;
            end
            out_valid_d   = 1'b1;
            out_d.kind    = tsb_pkg::KIND_CANCELLED;
            out_d.slot_id = in_i.slot_index;
            out_d.last    = 1'b1;
          end else if (in_i.opcode == tsb_pkg::OP_TICK) begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            cmp_idx_d = '0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        sum_wr_addr = cmp_idx_q;
        sum_wr_en   = scan_live;
        sum_wr_data = (scan_hit && periodic_q[cmp_idx_q]) ? '0 : sum_sat;
        if (scan_hit) begin
          if (!periodic_q[cmp_idx_q]) begin
            active_d[cmp_idx_q] = 1'b0;
          end
          out_valid_d   = 1'b1;
          out_d.kind    = tsb_pkg::KIND_EXPIRED;
          out_d.slot_id = 5'(cmp_idx_q);
          out_d.last    = 1'b0;
        end
        if (scan_last) begin
          state_d = ST_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = cmp_idx_q + tsb_pkg::SlotW'(1);
          cmp_idx_d = cmp_idx_q + tsb_pkg::SlotW'(1);
        end
      end
      ST_FIN: begin
        out_valid_d   = 1'b1;
        out_d.kind    = tsb_pkg::KIND_TICK_DONE;
        out_d.slot_id = '0;
        out_d.last    = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      active_q      <= '0;
      periodic_q    <= '0;
      cmp_idx_q     <= '0;
      out_valid_q   <= 1'b0;
      ms_per_tick_q <= tsb_pkg::MsPerTickRst;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      periodic_q  <= periodic_d;
      cmp_idx_q   <= cmp_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ms_per_tick_q <= cfg_data_i;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Period memory
  always_ff @(posedge clk_i) begin
    if (per_wr_en) begin
      mem_per[free_idx] <= in_i.period_ms;
    end
    if (rd_en) begin
      per_rd_q <= mem_per[rd_addr];
    end
  end

  // Accumulator memory
  always_ff @(posedge clk_i) begin
    if (sum_wr_en) begin
      mem_sum[sum_wr_addr] <= sum_wr_data;
    end
    if (rd_en) begin
      sum_rd_q <= mem_sum[rd_addr];
    end
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsb_pkg::*;

  // Opcode with no meaning to the bank; it is taken and dropped
  localparam logic [1:0] OpUnused = 2'd3;
  // Cycles without any transaction before the run is abandoned
  localparam int unsigned StallLimit = 4000;
  // Settle time after the last result: a tick scan plus margin
  localparam int unsigned DrainCycles = 40;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  cmd_t           in_i = '0;
  logic           busy_o;
  logic           out_valid_o;
  rsp_t           out_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [MsW-1:0] cfg_data_i = '0;

  timeout_slot_bank_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_i       (in_i),
    .busy_o     (busy_o),
    .out_valid_o(out_valid_o),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the bank
  logic              slot_busy [Slots];
  logic              slot_rep  [Slots];
  logic [PerW-1:0]   slot_per  [Slots];
  logic [PerW-1:0]   slot_acc  [Slots];
  logic [MsW-1:0]    tick_ms = MsPerTickRst;

  cmd_t        cmd_backlog[$];
  rsp_t        due_rsps[$];
  logic        cmd_taken = 1'b0;
  logic        no_gaps = 1'b0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  function automatic rsp_t mk_rsp(logic [2:0] kind, logic [4:0] slot, logic last);
    rsp_t r;
    r.kind    = kind;
    r.slot_id = slot;
    r.last    = last;
    return r;
  endfunction

  // Apply one command to the shadow bank and queue the results it should give
  function automatic void predict_bank_results(cmd_t c);
    logic [PerW:0] acc_next;
    bit            found;
    found = 0;
    case (c.opcode)
      OP_ARM: begin
        for (int i = 0; i < Slots; i++) begin
          if (!found && !slot_busy[i]) begin
            found        = 1;
            slot_busy[i] = 1'b1;
            slot_rep[i]  = c.repeat_req;
            slot_per[i]  = c.period_ms;
            slot_acc[i]  = '0;
            due_rsps.push_back(mk_rsp(KIND_ARMED, 5'(i), 1'b1));
          end
        end
        if (!found) due_rsps.push_back(mk_rsp(KIND_FULL, '0, 1'b1));
      end
      OP_CANCEL: begin
        if (c.slot_index < Slots) slot_busy[c.slot_index] = 1'b0;
        due_rsps.push_back(mk_rsp(KIND_CANCELLED, c.slot_index, 1'b1));
      end
      OP_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_busy[i] && slot_per[i] != '0) begin
            // saturating accumulate
            acc_next = {1'b0, slot_acc[i]} + (PerW+1)'(tick_ms);
            slot_acc[i] = acc_next[PerW] ? '1 : acc_next[PerW-1:0];
            if (slot_acc[i] >= slot_per[i]) begin
              if (slot_rep[i]) slot_acc[i] = '0;
              else slot_busy[i] = 1'b0;
              due_rsps.push_back(mk_rsp(KIND_EXPIRED, 5'(i), 1'b0));
            end
          end
        end
        due_rsps.push_back(mk_rsp(KIND_TICK_DONE, '0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  // Driver: present the next command at the falling edge, hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(start_i && !cmd_taken)) begin
        if (cmd_backlog.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 9)) begin
          in_i    <= cmd_backlog.pop_front();
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results, predict accepted commands, watchdog
  always @(posedge clk_i) begin
    rsp_t want;
    logic seen;
    if (rst_ni) begin
      seen = 1'b0;
      if (out_valid_o) begin
        seen = 1'b1;
        if (due_rsps.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected result kind %0d slot %0d last %0d",
                   $realtime, out_o.kind, out_o.slot_id, out_o.last);
        end else begin
          want = due_rsps.pop_front();
          if (out_o.kind !== want.kind || out_o.slot_id !== want.slot_id ||
              out_o.last !== want.last) begin
            fail_count <= fail_count + 1;
            $display("%0t: expected kind %0d slot %0d last %0d, got kind %0d slot %0d last %0d",
                     $realtime, want.kind, want.slot_id, want.last,
                     out_o.kind, out_o.slot_id, out_o.last);
          end
        end
      end
      cmd_taken <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        seen = 1'b1;
        predict_bank_results(in_i);
      end
      if (cfg_valid_i && cfg_ready_o) seen = 1'b1;
      quiet_cycles <= seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned roll;
    int unsigned span;
    span         = (tick_ms == '0) ? 50 : int'(tick_ms);
    c.slot_index = 5'($urandom);
    c.period_ms  = $urandom;
    c.repeat_req = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 45) c.opcode = OP_ARM;
    else if (roll < 65) c.opcode = OP_CANCEL;
    else if (roll < 95) c.opcode = OP_TICK;
    else c.opcode = OpUnused;
    // cancels lean toward the low slots, where arms land
    if (c.opcode == OP_CANCEL && $urandom_range(0, 1) == 1)
      c.slot_index = 5'($urandom_range(0, 11));
    // periods mostly within a few ticks so slots actually expire
    roll = $urandom_range(0, 9);
    if (roll == 0) c.period_ms = '0;
    else if (roll < 8) c.period_ms = $urandom_range(1, 6 * span);
    return c;
  endfunction

  task automatic push_cmd(logic [1:0] op, logic [4:0] idx, logic [31:0] per, logic rep);
    cmd_t c;
    c.opcode     = op;
    c.slot_index = idx;
    c.period_ms  = per;
    c.repeat_req = rep;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_random(int unsigned n);
    for (int i = 0; i < n; i++) cmd_backlog.push_back(rand_cmd());
  endtask

  // Wait until every command is taken and every result has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (cmd_backlog.size() != 0 || start_i || due_rsps.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tick_ms(logic [MsW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    tick_ms = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
  endtask

  // Stimulus
  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_busy[i] = 1'b0;
      slot_rep[i]  = 1'b0;
      slot_per[i]  = '0;
      slot_acc[i]  = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero period, short one-shot, longest periodic, periodic reload
    push_cmd(OP_ARM, 5'd31, 32'd0, 1'b0);
    push_cmd(OP_ARM, 5'd0, 32'd1, 1'b0);
    push_cmd(OP_ARM, 5'd0, 32'hFFFF_FFFF, 1'b1);
    push_cmd(OP_ARM, 5'd0, 32'd20, 1'b1);
    push_cmd(OpUnused, 5'd31, 32'hFFFF_FFFF, 1'b1);
    push_cmd(OP_TICK, 5'd0, 32'd0, 1'b0);
    push_cmd(OP_TICK, 5'd31, 32'hFFFF_FFFF, 1'b1);
    // cancel of a freed slot, of a never-armed top slot, of a live one
    push_cmd(OP_CANCEL, 5'd1, 32'd0, 1'b0);
    push_cmd(OP_CANCEL, 5'd31, 32'd0, 1'b0);
    push_cmd(OP_CANCEL, 5'd0, 32'd0, 1'b0);
    push_cmd(OP_ARM, 5'd0, 32'd10, 1'b0);
    push_cmd(OP_TICK, 5'd0, 32'd0, 1'b0);
    push_cmd(OP_TICK, 5'd0, 32'd0, 1'b0);
    wait_drained();

    write_tick_ms(10'd1000);
    queue_random(80);
    wait_drained();

    // fill the bank past full, then let the short timers run out
    write_tick_ms(10'd1);
    for (int i = 0; i < 36; i++) push_cmd(OP_ARM, 5'($urandom), $urandom_range(0, 4),
                                          1'($urandom));
    queue_random(60);
    wait_drained();

    write_tick_ms(10'h3FF);
    queue_random(80);
    wait_drained();

    write_tick_ms(10'd0);
    queue_random(40);
    wait_drained();

    // back-to-back commands with no gaps
    write_tick_ms(10'($urandom_range(1, 1000)));
    no_gaps = 1'b1;
    queue_random(60);
    wait_drained();
    no_gaps = 1'b0;
    queue_random(60);
    wait_drained();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
